// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the timer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define PILT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When cond holds, prop holds in the next cycle.
`define PILT_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ----- hdl/pilt_pkg.sv -----
// ----------------------------------------------------------------------------
// pilt_pkg
// Widths, codes, state types and structs of the pausable looping timer.
// ----------------------------------------------------------------------------
package pilt_pkg;

   // elapsed time width (saturation point)
   localparam int TIME_WIDTH = 32;

   localparam int CMD_W      = 3;
   localparam int DELTA_W    = 20;
   localparam int SPEED_W    = 16;
   localparam int DUR_W      = 32;
   localparam int STATE_W    = 2;
   localparam int PASSED_W   = 32;
   localparam int LEFT_W     = 33;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // serial multiplier: 2-bit digits of speed, MSB first
   localparam int FRAC_BITS  = 8;
   localparam int DIGIT_W    = 2;
   localparam int PROD_W     = DELTA_W + SPEED_W;
   localparam int PP_W       = DELTA_W + DIGIT_W;
   localparam int SCALED_W   = PROD_W - FRAC_BITS;
   localparam int MUL_STEPS  = SPEED_W / DIGIT_W;
   localparam int MUL_CNT_W  = $clog2(MUL_STEPS);

   localparam int SUM_W      = ((TIME_WIDTH > SCALED_W) ? TIME_WIDTH : SCALED_W) + 1;
   localparam int CMP_W      = (TIME_WIDTH > DUR_W) ? TIME_WIDTH : DUR_W;
   localparam int MOD_CNT_W  = $clog2(TIME_WIDTH);

   localparam logic [DUR_W-1:0]   DUR_RESET   = DUR_W'(1000000);
   localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(256);

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK    = 3'd0,
      CMD_RUN     = 3'd1,
      CMD_PAUSE   = 3'd2,
      CMD_STOP    = 3'd3,
      CMD_RESTART = 3'd4
   } cmd_type;

   typedef enum logic [STATE_W-1:0] {
      MODE_STOPPED = 2'd0,
      MODE_RUNNING = 2'd1,
      MODE_PAUSED  = 2'd2
   } run_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DURATION = 2'd0,
      CSR_SPEED    = 2'd1,
      CSR_LOOP     = 2'd2
   } csr_idx_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_ADD,
      S_CHK,
      S_MOD,
      S_OUT
   } fsm_type;

   typedef struct packed {
      logic                  start;
      logic [TIME_WIDTH-1:0] dividend;
      logic [DUR_W-1:0]      divisor;
   } mod_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mod_stat_type;

endpackage

// ----- hdl/pilt_req_if.sv -----
// ----------------------------------------------------------------------------
// pilt_req_if
// Command channel: valid/ready with command code and tick delta.
// ----------------------------------------------------------------------------
interface pilt_req_if import pilt_pkg::*; ();

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [DELTA_W-1:0] delta_us;

   modport source (output valid, output command, output delta_us, input ready);
   modport sink   (input valid, input command, input delta_us, output ready);

endinterface

// ----- hdl/pilt_rsp_if.sv -----
// ----------------------------------------------------------------------------
// pilt_rsp_if
// Snapshot channel: valid/ready with timer state after each command.
// ----------------------------------------------------------------------------
interface pilt_rsp_if import pilt_pkg::*; ();

   logic                     valid;
   logic                     ready;
   logic [STATE_W-1:0]       run_state;
   logic                     cycle_done;
   logic [PASSED_W-1:0]      time_passed;
   logic signed [LEFT_W-1:0] time_left;

   modport source (output valid, output run_state, output cycle_done,
                   output time_passed, output time_left, input ready);
   modport sink   (input valid, input run_state, input cycle_done,
                   input time_passed, input time_left, output ready);

endinterface

// ----- hdl/pilt_serial_mod.sv -----
// ----------------------------------------------------------------------------
// pilt_serial_mod
// Bit-serial restoring remainder: one dividend bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module pilt_serial_mod import pilt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  mod_req_type      req,
   output mod_stat_type     stat,
   output logic [DUR_W-1:0] rem
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [MOD_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [TIME_WIDTH-1:0] dvd_ff, dvd_in;
   logic [DUR_W-1:0]      div_ff, div_in;
   logic [DUR_W-1:0]      rem_ff, rem_in;
   logic [DUR_W:0]        trial;
   logic [DUR_W:0]        diff;

   always_comb begin
      trial   = {rem_ff, dvd_ff[TIME_WIDTH-1]};
      diff    = trial - {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = MOD_CNT_W'(TIME_WIDTH - 1);
         dvd_in  = req.dividend;
         div_in  = req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // remainder stays below divisor, so the shifted trial fits DUR_W+1 bits
         rem_in = (trial >= {1'b0, div_ff}) ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign rem       = rem_ff;

endmodule

// ----- hdl/pausable_looping_interval_timer.sv -----
// ----------------------------------------------------------------------------
// pausable_looping_interval_timer
// Stopped/running/paused interval timer with speed scaling and loop mode.
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | payload
//  --------+-----+------------------+--------------------------------------------
//  req     | in  | valid/ready      | command, delta_us
//  rsp     | out | valid/ready      | run_state, cycle_done, time_passed, time_left
//  csr     | in  | csr_we, no ready | csr_index, csr_wdata
//
//  Non-tick commands and ticks while not running pass from S_IDLE to S_OUT.
//  A running tick runs the 2-bit serial speed multiply in S_MUL, then add
//  (S_ADD) and end test (S_CHK). A wrap then waits in S_MOD on the serial
//  remainder unit before S_OUT.
//  Reset (synchronous) loads register defaults and a stopped timer at zero.
//  A new beat is taken while the last snapshot waits in the output register;
//  rsp stalls hold the machine in S_OUT only once a second snapshot is ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pausable_looping_interval_timer import pilt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   pilt_req_if.sink              req_bus,
   pilt_rsp_if.source            rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

   // configuration registers
   logic [DUR_W-1:0]   dur_ff;
   logic [SPEED_W-1:0] speed_ff;
   logic               loop_ff;

   // timer state
   fsm_type               state_ff, state_in;
   run_mode_type          mode_ff, mode_in;
   logic [TIME_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic                  done_ff, done_in;

   // serial multiplier
   logic [DELTA_W-1:0]    mcand_ff, mcand_in;
   logic [SPEED_W-1:0]    mplier_ff, mplier_in;
   logic [PROD_W-1:0]     acc_ff, acc_in;
   logic [MUL_CNT_W-1:0]  dig_cnt_ff, dig_cnt_in;
   logic [PP_W-1:0]       pp;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATE_W-1:0]       rsp_state_ff, rsp_state_in;
   logic                     rsp_done_ff, rsp_done_in;
   logic [PASSED_W-1:0]      rsp_passed_ff, rsp_passed_in;
   logic [LEFT_W-1:0]        rsp_left_ff, rsp_left_in;

   logic                  req_fire;
   logic                  tick_go;
   logic                  slot_free;
   logic                  reach;
   logic                  wrap_go;
   logic [SUM_W-1:0]      sum;
   logic [TIME_WIDTH-1:0] sum_sat;
   logic [TIME_WIDTH-1:0] dur_sat;
   logic [CMP_W:0]        left_full;

   mod_req_type      mod_req;
   mod_stat_type     mod_stat;
   logic [DUR_W-1:0] mod_rem;

   // ---------------------------------------------------------------------
   // configuration writes
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         dur_ff   <= DUR_RESET;
         speed_ff <= SPEED_RESET;
         loop_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DURATION: dur_ff   <= csr_wdata[DUR_W-1:0];
            CSR_SPEED:    speed_ff <= csr_wdata[SPEED_W-1:0];
            CSR_LOOP:     loop_ff  <= csr_wdata[0];
            default:      ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // shared decode
   // ---------------------------------------------------------------------
   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign tick_go       = (req_bus.command == CMD_TICK) && (mode_ff == MODE_RUNNING);
   assign slot_free     = !rsp_valid_ff || rsp_bus.ready;

   // scaled delta is the product without its eight fraction bits
   assign sum     = SUM_W'(elapsed_ff) + SUM_W'(acc_ff[PROD_W-1:FRAC_BITS]);
   assign sum_sat = (sum > SUM_W'(TIME_MAX)) ? TIME_MAX : TIME_WIDTH'(sum);
   assign dur_sat = (CMP_W'(dur_ff) > CMP_W'(TIME_MAX)) ? TIME_MAX : TIME_WIDTH'(dur_ff);
   assign reach   = CMP_W'(elapsed_ff) >= CMP_W'(dur_ff);
   // zero duration wraps straight to zero, no remainder needed
   assign wrap_go = reach && loop_ff && (dur_ff != '0);

   assign left_full = (CMP_W+1)'(dur_ff) - (CMP_W+1)'(elapsed_ff);

   // ---------------------------------------------------------------------
   // next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = tick_go ? S_MUL : S_OUT;
            end
         end
         S_MUL: begin
            if (dig_cnt_ff == '0) begin
               state_in = S_ADD;
            end
         end
         S_ADD: state_in = S_CHK;
         S_CHK: state_in = wrap_go ? S_MOD : S_OUT;
         S_MOD: begin
            if (mod_stat.done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // datapath and outputs
   // ---------------------------------------------------------------------
   always_comb begin
      case (mplier_ff[SPEED_W-1 -: DIGIT_W])
         2'd0:    pp = '0;
         2'd1:    pp = PP_W'(mcand_ff);
         2'd2:    pp = PP_W'(mcand_ff) << 1;
         default: pp = PP_W'(mcand_ff) + (PP_W'(mcand_ff) << 1);
      endcase
   end

   always_comb begin
      mode_in          = mode_ff;
      elapsed_in       = elapsed_ff;
      done_in          = done_ff;
      mcand_in         = mcand_ff;
      mplier_in        = mplier_ff;
      acc_in           = acc_ff;
      dig_cnt_in       = dig_cnt_ff;
      mod_req.start    = 1'b0;
      mod_req.dividend = elapsed_ff;
      mod_req.divisor  = dur_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_bus.ready;
      rsp_state_in     = rsp_state_ff;
      rsp_done_in      = rsp_done_ff;
      rsp_passed_in    = rsp_passed_ff;
      rsp_left_in      = rsp_left_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_bus.command)
                  CMD_TICK: begin
                     if (tick_go) begin
                        done_in    = 1'b0;
                        mcand_in   = req_bus.delta_us;
                        mplier_in  = speed_ff;
                        acc_in     = '0;
                        dig_cnt_in = MUL_CNT_W'(MUL_STEPS - 1);
                     end
                  end
                  CMD_RUN: begin
                     // run on a running timer acts as restart
                     if (mode_ff == MODE_RUNNING) begin
                        elapsed_in = '0;
                        done_in    = 1'b0;
                     end
                     mode_in = MODE_RUNNING;
                  end
                  CMD_PAUSE: begin
                     if (mode_ff == MODE_RUNNING) begin
                        mode_in = MODE_PAUSED;
                     end
                  end
                  CMD_STOP: begin
                     if (mode_ff != MODE_STOPPED) begin
                        mode_in    = MODE_STOPPED;
                        elapsed_in = dur_sat;
                        done_in    = 1'b0;
                     end
                  end
                  CMD_RESTART: begin
                     mode_in    = MODE_RUNNING;
                     elapsed_in = '0;
                     done_in    = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         S_MUL: begin
            acc_in     = (acc_ff << DIGIT_W) + PROD_W'(pp);
            mplier_in  = mplier_ff << DIGIT_W;
            dig_cnt_in = dig_cnt_ff - 1'b1;
         end
         S_ADD: elapsed_in = sum_sat;
         S_CHK: begin
            if (reach) begin
               done_in = 1'b1;
               if (!loop_ff) begin
                  mode_in = MODE_STOPPED;
               end else if (dur_ff == '0) begin
                  elapsed_in = '0;
               end else begin
                  mod_req.start = 1'b1;
               end
            end
         end
         S_MOD: begin
            if (mod_stat.done) begin
               elapsed_in = TIME_WIDTH'(mod_rem);
            end
         end
         S_OUT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_state_in  = mode_ff;
               rsp_done_in   = done_ff;
               rsp_passed_in = PASSED_W'(elapsed_ff);
               rsp_left_in   = left_full[LEFT_W-1:0];
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_STOPPED;
         elapsed_ff   <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         elapsed_ff   <= elapsed_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mcand_ff      <= mcand_in;
      mplier_ff     <= mplier_in;
      acc_ff        <= acc_in;
      dig_cnt_ff    <= dig_cnt_in;
      rsp_state_ff  <= rsp_state_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_passed_ff <= rsp_passed_in;
      rsp_left_ff   <= rsp_left_in;
   end

   // wrap remainder: elapsed mod duration
   pilt_serial_mod u_mod (
      .clock (clock),
      .reset (reset),
      .req   (mod_req),
      .stat  (mod_stat),
      .rem   (mod_rem)
   );

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.run_state   = rsp_state_ff;
   assign rsp_bus.cycle_done  = rsp_done_ff;
   assign rsp_bus.time_passed = rsp_passed_ff;
   assign rsp_bus.time_left   = signed'(rsp_left_ff);

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   `PILT_ASSERT(a_mod_nonzero, clock, reset, mod_req.start |-> (dur_ff != '0), "remainder by zero")
   `PILT_ASSERT(a_mod_alive, clock, reset, (state_ff == S_MOD) |-> (mod_stat.busy || mod_stat.done), "waiting on idle remainder unit")
   `PILT_ASSERT_NEXT(a_wrap_below, clock, reset, (state_ff == S_MOD) && mod_stat.done, CMP_W'(elapsed_ff) < CMP_W'(dur_ff), "wrapped time not below duration")
   `PILT_ASSERT_NEXT(a_oneshot_stop, clock, reset, (state_ff == S_CHK) && reach && !loop_ff, (mode_ff == MODE_STOPPED) && done_ff, "one-shot end did not stop")

endmodule

// ----- tb/sv/pausable_looping_interval_timer_test.sv -----
// ----------------------------------------------------------------------------
// pausable_looping_interval_timer_test
// Self-checking bench for the pausable looping interval timer. A queue of
// commands feeds a valid/ready driver. A behavioral timer model predicts one
// snapshot per accepted command beat. A monitor compares each snapshot beat
// with the oldest prediction while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module pausable_looping_interval_timer_test import pilt_pkg::*; ;

   timeunit 1ns;
   timeprecision 1ps;

   // codes past the last defined command; the timer must ignore them
   localparam logic [CMD_W-1:0]     CMD_FIRST_UNUSED = 3'd5;
   localparam logic [CMD_W-1:0]     CMD_LAST_CODE    = 3'd7;
   // register index with nothing behind it
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED     = 2'd3;
   localparam logic [DELTA_W-1:0]   DELTA_MAX        = '1;
   localparam logic [TIME_WIDTH-1:0] TIME_MAX        = '1;
   localparam int                   CYCLE_LIMIT      = 400000;
   localparam int                   MAX_REPORTS      = 10;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [DELTA_W-1:0] delta_us;
   } timer_cmd_type;

   typedef struct packed {
      logic [STATE_W-1:0]  run_state;
      logic                cycle_done;
      logic [PASSED_W-1:0] time_passed;
      logic [LEFT_W-1:0]   time_left;
   } snapshot_type;

   logic clock;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pilt_req_if req_bus ();
   pilt_rsp_if rsp_bus ();

   pausable_looping_interval_timer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // Timer model: its own copy of the registers and the timer state
   // -------------------------------------------------------------------------
   logic [DUR_W-1:0]      duration_q;
   logic [SPEED_W-1:0]    speed_q;
   logic                  loop_q;
   run_mode_type          mode_q;
   logic [TIME_WIDTH-1:0] elapsed_q;
   logic                  done_q;

   timer_cmd_type pending_cmds[$];        // commands not yet offered
   snapshot_type  expected_snapshots[$];  // predictions awaiting a rsp beat
   timer_cmd_type offered_cmd;            // command currently on the req bus

   int unsigned req_idle_pct;
   int unsigned rsp_stall_pct;
   int          mismatches;
   int          cycle_count;

   // Advance the model by one command and return the snapshot it gives.
   function automatic snapshot_type apply_timer_command(timer_cmd_type c);
      logic [63:0]  sum;
      snapshot_type snap;
      case (c.command)
         CMD_TICK: begin
            // ticks only count while running
            if (mode_q == MODE_RUNNING) begin
               done_q = 1'b0;
               // UQ8.8 speed, product truncated, elapsed saturates
               sum = 64'(elapsed_q) + ((64'(c.delta_us) * 64'(speed_q)) >> FRAC_BITS);
               elapsed_q = (sum > 64'(TIME_MAX)) ? TIME_MAX : sum[TIME_WIDTH-1:0];
               if (elapsed_q >= duration_q) begin
                  done_q = 1'b1;
                  if (loop_q) begin
                     // zero duration wraps straight to zero
                     elapsed_q = (duration_q == '0) ? '0 : elapsed_q % duration_q;
                  end else begin
                     mode_q = MODE_STOPPED;
                  end
               end
            end
         end
         CMD_RUN: begin
            // run on a running timer restarts it; otherwise resume as is
            if (mode_q == MODE_RUNNING) begin
               elapsed_q = '0;
               done_q    = 1'b0;
            end
            mode_q = MODE_RUNNING;
         end
         CMD_PAUSE: begin
            if (mode_q == MODE_RUNNING) mode_q = MODE_PAUSED;
         end
         CMD_STOP: begin
            if (mode_q != MODE_STOPPED) begin
               mode_q    = MODE_STOPPED;
               // duration saturated to the elapsed width
               elapsed_q = (64'(duration_q) > 64'(TIME_MAX)) ? TIME_MAX
                                                             : TIME_WIDTH'(duration_q);
               done_q    = 1'b0;
            end
         end
         CMD_RESTART: begin
            mode_q    = MODE_RUNNING;
            elapsed_q = '0;
            done_q    = 1'b0;
         end
         default: ;  // unused codes leave the state alone
      endcase
      snap.run_state   = mode_q;
      snap.cycle_done  = done_q;
      snap.time_passed = elapsed_q[PASSED_W-1:0];
      snap.time_left   = LEFT_W'({1'b0, duration_q}) - LEFT_W'({1'b0, elapsed_q});
      return snap;
   endfunction

   // -------------------------------------------------------------------------
   // Clock and timeout
   // -------------------------------------------------------------------------
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("pausable_looping_interval_timer: mismatch");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Driver: offers queued commands, predicts on every accepted beat.
   // Valid gets at most one NBA per edge, so back-to-back beats stay high.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : cmd_driver
      logic slot_free;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         slot_free = !req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            expected_snapshots.push_back(apply_timer_command(offered_cmd));
            slot_free = 1'b1;
         end
         if (slot_free) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
               offered_cmd       = pending_cmds.pop_front();
               req_bus.valid    <= 1'b1;
               req_bus.command  <= offered_cmd.command;
               req_bus.delta_us <= offered_cmd.delta_us;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: checks each snapshot beat, then picks ready for the next edge
   // -------------------------------------------------------------------------
   function automatic void report_mismatch(string what, snapshot_type want,
                                           snapshot_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t %s: expected state %0d done %0d passed %0d left %0d, got state %0d done %0d passed %0d left %0d",
                  $realtime, what, want.run_state, want.cycle_done, want.time_passed,
                  $signed(want.time_left), got.run_state, got.cycle_done, got.time_passed,
                  $signed(got.time_left));
   endfunction

   always @(posedge clock) begin : snapshot_monitor
      snapshot_type got;
      snapshot_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.run_state   = rsp_bus.run_state;
            got.cycle_done  = rsp_bus.cycle_done;
            got.time_passed = rsp_bus.time_passed;
            got.time_left   = rsp_bus.time_left;
            if (expected_snapshots.size() == 0) begin
               report_mismatch("unexpected snapshot", '0, got);
            end else begin
               want = expected_snapshots.pop_front();
               if (got.run_state   !== want.run_state   ||
                   got.cycle_done  !== want.cycle_done  ||
                   got.time_passed !== want.time_passed ||
                   got.time_left   !== want.time_left)
                  report_mismatch("snapshot", want, got);
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      // timer is idle here, so the model can take the value at once
      case (idx)
         CSR_DURATION: duration_q = data[DUR_W-1:0];
         CSR_SPEED:    speed_q    = data[SPEED_W-1:0];
         CSR_LOOP:     loop_q     = data[0];
         default: ;
      endcase
   endtask

   // raw words: upper bits past a register's width must be dropped
   task automatic set_timer_config(input logic [CSR_DATA_W-1:0] dur,
                                   input logic [CSR_DATA_W-1:0] spd,
                                   input logic [CSR_DATA_W-1:0] lp);
      write_csr(CSR_DURATION, dur);
      write_csr(CSR_SPEED, spd);
      write_csr(CSR_LOOP, lp);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // sampled on the falling edge, clear of the posedge updates
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_cmds.size() != 0 || req_bus.valid || expected_snapshots.size() != 0);
   endtask

   task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [DELTA_W-1:0] delta);
      timer_cmd_type c;
      c.command  = cmd;
      c.delta_us = delta;
      pending_cmds.push_back(c);
   endtask

   function automatic logic [DELTA_W-1:0] random_delta();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 40)      return DELTA_W'($urandom_range(0, 3000));
      else if (pick < 75) return DELTA_W'($urandom_range(0, 1000000));
      else if (pick < 90) return DELTA_MAX - DELTA_W'($urandom_range(0, 3));
      else                return DELTA_W'($urandom);
   endfunction

   function automatic timer_cmd_type random_command(int unsigned tick_pct);
      timer_cmd_type c;
      int unsigned   pick;
      c.delta_us = random_delta();
      if ($urandom_range(99) < tick_pct) begin
         c.command = CMD_TICK;
      end else begin
         pick = $urandom_range(99);
         if (pick < 30)      c.command = CMD_RUN;
         else if (pick < 50) c.command = CMD_PAUSE;
         else if (pick < 65) c.command = CMD_STOP;
         else if (pick < 94) c.command = CMD_RESTART;
         else                c.command = CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_CODE));
      end
      return c;
   endfunction

   // One random phase: configure, then two batches with a full drain between,
   // so the sender also sits idle until every snapshot is back.
   task automatic run_random_phase(input logic [CSR_DATA_W-1:0] dur,
                                   input logic [CSR_DATA_W-1:0] spd,
                                   input logic [CSR_DATA_W-1:0] lp,
                                   input int unsigned idle_pct,
                                   input int unsigned stall_pct,
                                   input int unsigned tick_pct);
      set_timer_config(dur, spd, lp);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (2) begin
         repeat (60) pending_cmds.push_back(random_command(tick_pct));
         wait_idle();
      end
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.command  = '0;
      req_bus.delta_us = '0;
      rsp_bus.ready    = 1'b0;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_idle_pct     = 0;
      rsp_stall_pct    = 0;
      mismatches       = 0;
      cycle_count      = 0;
      duration_q       = DUR_RESET;
      speed_q          = SPEED_RESET;
      loop_q           = 1'b0;
      mode_q           = MODE_STOPPED;
      elapsed_q        = '0;
      done_q           = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: one-shot, 1000 us, unit speed
      set_timer_config(32'd1000, 32'd256, 32'd0);
      queue_cmd(CMD_TICK, 20'd5);            // stopped: ignored
      queue_cmd(CMD_PAUSE, 20'd0);           // stopped: ignored
      queue_cmd(CMD_STOP, 20'd0);            // already stopped
      queue_cmd(CMD_FIRST_UNUSED, DELTA_MAX);
      queue_cmd(CMD_LAST_CODE, 20'd0);
      queue_cmd(CMD_RUN, 20'd0);             // resume from stopped
      queue_cmd(CMD_TICK, 20'd0);
      queue_cmd(CMD_TICK, 20'd400);
      queue_cmd(CMD_PAUSE, 20'd0);
      queue_cmd(CMD_TICK, DELTA_MAX);        // paused: ignored
      queue_cmd(CMD_RUN, 20'd0);             // resume keeps 400
      queue_cmd(CMD_TICK, 20'd700);          // overshoot, stops, time left < 0
      queue_cmd(CMD_RUN, 20'd0);             // resume keeps done and overshoot
      queue_cmd(CMD_RUN, 20'd0);             // run while running = restart
      queue_cmd(CMD_PAUSE, 20'd0);
      queue_cmd(CMD_STOP, 20'd0);            // from paused: elapsed = duration
      queue_cmd(CMD_RESTART, 20'd0);
      queue_cmd(CMD_TICK, DELTA_MAX);
      wait_idle();

      // directed: zero duration in loop mode, zero speed
      set_timer_config(32'd0, 32'd0, 32'd1);
      queue_cmd(CMD_RESTART, 20'd0);
      queue_cmd(CMD_TICK, 20'd0);            // any running tick ends a cycle
      queue_cmd(CMD_TICK, DELTA_MAX);
      queue_cmd(CMD_STOP, 20'd0);
      wait_idle();

      // directed: stop parks elapsed near the top, next tick saturates, wraps
      set_timer_config(32'hFFFF_FF00, 32'd256, 32'd1);
      queue_cmd(CMD_RESTART, 20'd0);
      queue_cmd(CMD_STOP, 20'd0);
      queue_cmd(CMD_RUN, 20'd0);
      queue_cmd(CMD_TICK, 20'd1000);
      wait_idle();

      // random phases: idling pattern, registers and command mix vary
      run_random_phase(32'd5000, 32'd256, 32'd1, 0, 0, 65);
      run_random_phase(32'($urandom_range(1, 20000)), $urandom, 32'd0, 77, 0, 65);
      run_random_phase(32'hFFFF_FFFF, 32'h0000_FFFF, 32'd1, 0, 77, 90);
      write_csr(CSR_UNMAPPED, $urandom);
      run_random_phase(32'd1, {16'($urandom), 16'd128}, {31'($urandom), 1'b1}, 10, 10, 65);
      run_random_phase($urandom, $urandom, $urandom, 0, 0, 65);
      run_random_phase(32'd300000, 32'($urandom_range(0, 65535)), 32'd0, 77, 0, 65);
      run_random_phase(32'($urandom_range(1, 4000)), 32'($urandom_range(1, 1024)), 32'd1,
                       0, 77, 70);

      // let any stray beat surface before the verdict
      repeat (60) @(posedge clock);
      if (mismatches == 0) begin
         $display("pausable_looping_interval_timer: match");
      end else begin
         $display("pausable_looping_interval_timer: mismatch");
      end
      $finish;
   end

endmodule

// ----- pausable_looping_interval_timer.f -----
+incdir+hdl
hdl/pilt_pkg.sv
hdl/pilt_req_if.sv
hdl/pilt_rsp_if.sv
hdl/pilt_serial_mod.sv
hdl/pausable_looping_interval_timer.sv
tb/sv/pausable_looping_interval_timer_test.sv
